// ----- rtl/bcc_pkg.sv -----
// ---------------------------------------------------------------------------
// Button click classifier package
// Shared types and constants for the classifier channels and core.
// ---------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned COUNT_W     = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LONG_PRESS = 1'b0,
    CFG_CLICK_GAP  = 1'b1
  } cfg_index_t;

  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] CLICK_GAP_RESET  = 16'd300;

  // Event codes reported with each item.
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_code_t;

  // Button sequence status. Code three is never produced and reads as idle.
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_PRESSED  = 2'd1;
  localparam logic [1:0] ST_RELEASED = 2'd2;

endpackage

// ----- rtl/bcc_if.sv -----
// ---------------------------------------------------------------------------
// Button click classifier channels
// Valid/ready channels for button ticks, classified results and register
// writes.
// ---------------------------------------------------------------------------
interface bcc_tick_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

interface bcc_result_if;
  import bcc_pkg::*;

  logic        valid;
  logic        ready;
  event_code_t event_code;
  logic        sequence_done;

  modport source (output valid, output event_code, output sequence_done, input ready);
  modport sink (input valid, input event_code, input sequence_done, output ready);
endinterface

interface bcc_cfg_if;
  import bcc_pkg::*;

  logic                  valid;
  logic                  ready;
  cfg_index_t            index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/button_click_classifier_core.sv -----
// ---------------------------------------------------------------------------
// Button click classifier core
// Sorts sampled button levels into clicks, double clicks and long presses.
// ---------------------------------------------------------------------------
// Each result item is registered, offered the cycle after its tick. Throughput:
// one tick item per cycle unless the result stalls; the update is a pair of
// saturating increments and threshold compares ahead of the result register.
// Reset (rst, synchronous, active high) clears the sequence state, empties
// the result register and loads the thresholds with 1000 and 300 ticks.
// ---------------------------------------------------------------------------
module button_click_classifier_core #(
  parameter int unsigned TIMER_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  bcc_tick_if.sink    tick,
  bcc_result_if.source result,
  bcc_cfg_if.sink     cfg
);
  import bcc_pkg::*;

  // Compares run at the wider of the timer and threshold widths, so a
  // threshold beyond the timer range is simply never reached.
  localparam int unsigned CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] long_press_ticks;
  logic [CFG_DATA_W-1:0] click_gap_ticks;

  // Sequence state.
  logic [1:0]            press_status;
  logic [TIMER_BITS-1:0] press_timer;
  logic [TIMER_BITS-1:0] gap_timer;
  logic [COUNT_W-1:0]    release_count;

  logic [1:0]            press_status_next;
  logic [TIMER_BITS-1:0] press_timer_next;
  logic [TIMER_BITS-1:0] gap_timer_next;
  logic [COUNT_W-1:0]    release_count_next;

  // Result register.
  logic        out_valid;
  event_code_t out_event;
  logic        out_done;
  event_code_t event_next;
  logic        done_next;

  logic                  tick_fire;
  logic [1:0]            status_step;
  logic [COUNT_W-1:0]    count_step;
  logic [TIMER_BITS-1:0] press_timer_inc;
  logic [TIMER_BITS-1:0] gap_timer_inc;
  logic                  long_reached_inc;
  logic                  long_reached_held;
  logic                  gap_reached;

  // The result register parts the two sides: a new tick is taken whenever
  // the register is empty or its item leaves in this same cycle. Nothing is
  // taken while reset is held.
  assign tick.ready = !rst && (!out_valid || result.ready);
  assign tick_fire  = tick.valid && tick.ready;

  // Configuration writes are taken whenever the core is out of reset.
  assign cfg.ready = !rst;

  assign result.valid         = out_valid;
  assign result.event_code    = out_event;
  assign result.sequence_done = out_done;

  // Saturating timer increments.
  assign press_timer_inc = (&press_timer) ? press_timer : press_timer + 1'b1;
  assign gap_timer_inc   = (&gap_timer) ? gap_timer : gap_timer + 1'b1;

  assign long_reached_inc  = CMP_W'(press_timer_inc) >= CMP_W'(long_press_ticks);
  assign long_reached_held = CMP_W'(press_timer) >= CMP_W'(long_press_ticks);
  assign gap_reached       = CMP_W'(gap_timer_inc) >= CMP_W'(click_gap_ticks);

  always_comb begin
    // First the level updates the status; a falling level after a press
    // counts one release, saturating at the top of the counter.
    status_step = press_status;
    count_step  = release_count;
    if (tick.button_level) begin
      status_step = ST_PRESSED;
    end else if (press_status == ST_PRESSED) begin
      status_step = ST_RELEASED;
      if (!(&release_count)) begin
        count_step = release_count + 1'b1;
      end
    end

    press_status_next  = status_step;
    press_timer_next   = press_timer;
    gap_timer_next     = gap_timer;
    release_count_next = count_step;
    event_next         = EV_NONE;
    done_next          = 1'b0;

    case (status_step)
      ST_PRESSED: begin
        // Long click reported on every pressed tick at or past the threshold.
        press_timer_next = press_timer_inc;
        if (long_reached_inc) begin
          event_next = EV_LONG;
        end
      end
      ST_RELEASED: begin
        if (long_reached_held) begin
          // Release after a long press: clear at once, the gap timer stays.
          press_status_next  = ST_IDLE;
          press_timer_next   = '0;
          release_count_next = '0;
          done_next          = 1'b1;
        end else begin
          gap_timer_next = gap_timer_inc;
          if (gap_reached) begin
            // Resolve the counted releases; other counts give no event.
            if (count_step == COUNT_W'(1)) begin
              event_next = EV_CLICK;
            end else if (count_step == COUNT_W'(2)) begin
              event_next = EV_DOUBLE;
            end
            press_status_next  = ST_IDLE;
            press_timer_next   = '0;
            gap_timer_next     = '0;
            release_count_next = '0;
            done_next          = 1'b1;
          end
        end
      end
      default: begin
        // Idle, and the unused status code, leave everything as it is.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RESET;
      click_gap_ticks  <= CLICK_GAP_RESET;
      press_status     <= ST_IDLE;
      press_timer      <= '0;
      gap_timer        <= '0;
      release_count    <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_LONG_PRESS: long_press_ticks <= cfg.data;
          CFG_CLICK_GAP:  click_gap_ticks  <= cfg.data;
          default: begin
          end
        endcase
      end
      if (tick_fire) begin
        press_status  <= press_status_next;
        press_timer   <= press_timer_next;
        gap_timer     <= gap_timer_next;
        release_count <= release_count_next;
        out_valid     <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it loads with each accepted tick.
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_event <= event_next;
      out_done  <= done_next;
    end
  end

  // A long click never comes with the end of a sequence.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_event == EV_LONG && out_done))
    else $error("long click reported together with sequence end");

  // A click or double click is only ever reported as a sequence resolves.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_event == EV_CLICK || out_event == EV_DOUBLE)) |-> out_done)
    else $error("click reported without resolving the sequence");

  // A pressed tick can only yield a long click or nothing, never an ending.
  assert property (@(posedge clk) disable iff (rst)
    (tick_fire && tick.button_level) |=>
      (!out_done && (out_event == EV_NONE || out_event == EV_LONG)))
    else $error("pressed tick resolved a sequence");

  // Reset leaves the result register empty.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
